[rtl/assert_macros.svh]
// assertion helpers for the debounce block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property checked on every rising clock edge outside reset
`define DBE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("debounce assertion failed");
// implication from one cycle to the next
`define DBE_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("debounce assertion failed");
`else
`define DBE_ASSERT(lbl, clk, rst, prop)
`define DBE_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif

`endif

[rtl/dbe_pkg.sv]
`default_nettype none

package dbe_pkg;

   localparam int NUM_BUTTONS = 13;
   localparam int IDX_W       = 4;
   localparam int TIME_W      = 32;
   localparam int DEB_W       = 16;
   localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 16'd50;

   typedef struct packed {
      logic [NUM_BUTTONS-1:0] button_levels;
      logic [TIME_W-1:0]      now_ms;
      logic                   link_ready;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] button_index;
      logic             is_press;
      logic [IDX_W-1:0] report_value;
      logic             reported;
      logic             last_event;
   } rsp_type;

   // events found in one poll, handed from the channel bank to the emitter
   typedef struct packed {
      logic [NUM_BUTTONS-1:0] event_mask;
      logic [NUM_BUTTONS-1:0] press_mask;
      logic                   link;
   } batch_type;

endpackage

`default_nettype wire

[rtl/dbe_channels.sv]
`default_nettype none

module dbe_channels
   import dbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire req_type          poll,
   input  wire logic             advance,
   input  wire logic [DEB_W-1:0] hold_ms,
   output batch_type             batch
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_PRESSED  = 2'd2,
      PH_RELEASE  = 2'd3
   } phase_type;

   phase_type         phase_ff [NUM_BUTTONS];
   phase_type         phase_in [NUM_BUTTONS];
   logic [TIME_W-1:0] stamp_ff [NUM_BUTTONS];
   logic [NUM_BUTTONS-1:0] stamp_we;

   always_comb begin
      batch.link       = poll.link_ready;
      batch.event_mask = '0;
      batch.press_mask = '0;
      stamp_we         = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         logic              low;
         logic [TIME_W-1:0] age;
         logic              matured;
         low         = ~poll.button_levels[i];
         // wrapping difference, so a backwards clock looks very old
         age         = poll.now_ms - stamp_ff[i];
         matured     = age >= {{(TIME_W-DEB_W){1'b0}}, hold_ms};
         phase_in[i] = phase_ff[i];
         unique case (phase_ff[i])
            PH_IDLE: begin
               if (low) begin
                  stamp_we[i] = 1'b1;
                  phase_in[i] = PH_DEBOUNCE;
               end
            end
            PH_DEBOUNCE: begin
               if (!low) begin
                  phase_in[i] = PH_IDLE;
               end else if (matured) begin
                  batch.event_mask[i] = 1'b1;
                  batch.press_mask[i] = 1'b1;
                  phase_in[i]         = PH_PRESSED;
               end
            end
            PH_PRESSED: begin
               if (!low) begin
                  stamp_we[i] = 1'b1;
                  phase_in[i] = PH_RELEASE;
               end
            end
            PH_RELEASE: begin
               if (low) begin
                  phase_in[i] = PH_PRESSED;
               end else if (matured) begin
                  batch.event_mask[i] = 1'b1;
                  phase_in[i]         = PH_IDLE;
               end
            end
            default: phase_in[i] = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (reset) begin
            phase_ff[i] <= PH_IDLE;
         end else if (advance) begin
            phase_ff[i] <= phase_in[i];
         end
         if (advance && stamp_we[i]) begin
            stamp_ff[i] <= poll.now_ms;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/dbe_emitter.sv]
`default_nettype none

`include "assert_macros.svh"

module dbe_emitter
   import dbe_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire batch_type batch,
   input  wire logic      load,
   output logic           buf_free,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output rsp_type        rsp_data
);

   logic [NUM_BUTTONS-1:0] mask_ff, mask_in;
   logic [NUM_BUTTONS-1:0] press_ff;
   logic                   link_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;

   logic [NUM_BUTTONS-1:0] pick, rest;
   logic [IDX_W-1:0]       pick_idx;
   logic                   out_free, emit;

   // lowest pending button goes first
   assign pick     = mask_ff & (~mask_ff + {{(NUM_BUTTONS-1){1'b0}}, 1'b1});
   assign rest     = mask_ff & ~pick;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (mask_ff != '0) && out_free;
   assign buf_free = (mask_ff == '0) || (emit && rest == '0);

   always_comb begin
      pick_idx = '0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         if (pick[i]) begin
            pick_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      rsp_in.button_index = pick_idx;
      rsp_in.is_press     = |(pick & press_ff);
      rsp_in.report_value = rsp_in.is_press ? pick_idx + {{(IDX_W-1){1'b0}}, 1'b1} : '0;
      rsp_in.reported     = link_ff;
      rsp_in.last_event   = (rest == '0);
   end

   always_comb begin
      priority if (load) begin
         mask_in = batch.event_mask;
      end else if (emit) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff <= mask_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         press_ff <= batch.press_mask;
         link_ff  <= batch.link;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `DBE_ASSERT(a_load_when_free, clock, reset, !load || buf_free)
   `DBE_ASSERT_NEXT(a_pending_drains, clock, reset,
                    (mask_ff != '0) && out_free && !load, rsp_valid_ff)
   `DBE_ASSERT_NEXT(a_taken_clears, clock, reset,
                    rsp_valid_ff && !rsp_stall && !emit, !rsp_valid_ff)

endmodule

`default_nettype wire

[rtl/multi_button_debounce_events.sv]
`default_nettype none

// Button debounce event generator. Each req transfer is one poll of all
// buttons (active-low levels, millisecond time, link-ready flag). A poll is
// taken into an input register, then every button's four-phase machine
// advances in the same cycle as the poll's events are loaded into an event
// buffer; the buffer sends one rsp transfer per event, in button order, the
// final one flagged with last_event. The result port moves one event per
// cycle while rsp is not stalled, and the next poll waits in the input
// register until the buffer has sent the last event of the one before, at
// most NUM_BUTTONS (13) events. One more poll is taken into the input
// register while results still drain. The debounce time is written through
// the csr port, which is always ready; write it only while no poll is in
// flight.
module multi_button_debounce_events
   import dbe_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire req_type          req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [DEB_W-1:0] csr_data
);

   logic             in_valid_ff;
   req_type          in_ff;
   logic [DEB_W-1:0] debounce_ff;
   logic             buf_free, advance;
   batch_type        batch;

   assign advance   = in_valid_ff && buf_free;
   assign req_stall = in_valid_ff && !buf_free;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         debounce_ff <= DEBOUNCE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            debounce_ff <= csr_data;
         end
      end
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   dbe_channels u_channels (
      .clock   (clock),
      .reset   (reset),
      .poll    (in_ff),
      .advance (advance),
      .hold_ms (debounce_ff),
      .batch   (batch)
   );

   dbe_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .batch     (batch),
      .load      (advance),
      .buf_free  (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
